/* rtl/ipv4_trie_longest_prefix_match_core_defines.svh */
// Assertion macros shared by the checker of the route table core.
`ifndef IPV4_TRIE_LONGEST_PREFIX_MATCH_CORE_DEFINES_SVH
`define IPV4_TRIE_LONGEST_PREFIX_MATCH_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define LPM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define LPM_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/ipv4lpm_pkg.sv */
// Types, constants and codes shared by the route table core.
`default_nettype none
package ipv4lpm_pkg;

    localparam int NODE_COUNT = 4096;
    localparam int ADDR_BITS  = 32;
    localparam int IDX_W      = $clog2(NODE_COUNT);
    localparam int CNT_W      = $clog2(NODE_COUNT + 1);
    localparam int LEVEL_W    = $clog2(ADDR_BITS + 1);
    localparam int LEN_W      = 6;
    localparam int PORT_W     = 8;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    typedef logic [IDX_W-1:0] node_idx_t;

    typedef struct packed {
        node_idx_t         left;
        node_idx_t         right;
        logic              valid;
        logic [PORT_W-1:0] port;
    } node_t;

    typedef struct packed {
        logic      en;
        node_idx_t idx;
    } rd_req_t;

    typedef struct packed {
        logic      en;
        node_idx_t idx;
        node_t     entry;
    } wr_req_t;

    typedef struct packed {
        logic              strobe;
        logic              found;
        logic [PORT_W-1:0] port;
        logic              pool_full;
    } result_t;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } state_t;

endpackage
`default_nettype wire

/* rtl/ipv4lpm_node_store.sv */
// Trie node store: root node in registers, all other nodes in a synchronous memory.
`default_nettype none
module ipv4lpm_node_store (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ipv4lpm_pkg::rd_req_t rd,
    input  wire ipv4lpm_pkg::wr_req_t wr,
    output ipv4lpm_pkg::node_t      rd_data,
    output ipv4lpm_pkg::node_t      root
);

    ipv4lpm_pkg::node_t mem [ipv4lpm_pkg::NODE_COUNT];
    ipv4lpm_pkg::node_t rd_data_reg;
    ipv4lpm_pkg::node_t root_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en && (wr.idx != '0))
        begin
            mem[wr.idx] <= wr.entry;
        end
        if (rd.en)
        begin
            rd_data_reg <= mem[rd.idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_reg <= '0;
        end
        else if (wr.en && (wr.idx == '0))
        begin
            root_reg <= wr.entry;
        end
    end

    assign rd_data = rd_data_reg;
    assign root    = root_reg;

endmodule
`default_nettype wire

/* rtl/ipv4lpm_walker.sv */
// Trie walk sequencer: one level per cycle for inserts and lookups, with node allocation.
`default_nettype none
module ipv4lpm_walker (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic                                kind,
    input  wire logic [31:0]                         address,
    input  wire logic [ipv4lpm_pkg::LEN_W-1:0]       prefix_length,
    input  wire logic [ipv4lpm_pkg::PORT_W-1:0]      port_in,
    input  wire ipv4lpm_pkg::node_t                  rd_data,
    input  wire ipv4lpm_pkg::node_t                  root,
    output ipv4lpm_pkg::rd_req_t                     rd,
    output ipv4lpm_pkg::wr_req_t                     wr,
    output ipv4lpm_pkg::result_t                     result
);

    ipv4lpm_pkg::state_t                        state_reg, state_next;
    logic                                       kind_reg, kind_next;
    logic [ipv4lpm_pkg::ADDR_BITS-1:0]          addr_reg, addr_next;
    logic [ipv4lpm_pkg::LEVEL_W-1:0]            len_reg, len_next;
    logic [ipv4lpm_pkg::PORT_W-1:0]             port_reg, port_next;
    logic [ipv4lpm_pkg::LEVEL_W-1:0]            level_reg, level_next;
    ipv4lpm_pkg::node_idx_t                     cur_reg, cur_next;
    ipv4lpm_pkg::node_t                         ent_reg, ent_next;
    logic                                       from_mem_reg, from_mem_next;
    logic                                       have_reg, have_next;
    logic [ipv4lpm_pkg::PORT_W-1:0]             best_reg, best_next;
    logic [ipv4lpm_pkg::CNT_W-1:0]              used_reg, used_next;

    ipv4lpm_pkg::node_t                         ent;
    ipv4lpm_pkg::node_t                         upd;
    ipv4lpm_pkg::node_idx_t                     nxt;
    ipv4lpm_pkg::node_idx_t                     new_idx;
    logic                                       addr_bit;
    logic                                       hit;
    logic                                       have_eff;
    logic [ipv4lpm_pkg::PORT_W-1:0]             best_eff;
    logic                                       ins_end;
    logic                                       look_end;
    logic                                       pool_empty;
    logic                                       finish;
    logic [ipv4lpm_pkg::LEVEL_W-1:0]            len_clip;

    assign ent        = from_mem_reg ? rd_data : ent_reg;
    assign addr_bit   = addr_reg[ipv4lpm_pkg::ADDR_BITS-1];
    assign nxt        = addr_bit ? ent.right : ent.left;
    assign hit        = from_mem_reg && ent.valid;
    assign have_eff   = have_reg || hit;
    assign best_eff   = hit ? ent.port : best_reg;
    assign ins_end    = (level_reg == len_reg);
    assign look_end   = (level_reg == ipv4lpm_pkg::LEVEL_W'(ipv4lpm_pkg::ADDR_BITS))
                        || (nxt == '0);
    assign pool_empty = (used_reg == ipv4lpm_pkg::CNT_W'(ipv4lpm_pkg::NODE_COUNT));
    assign new_idx    = used_reg[ipv4lpm_pkg::IDX_W-1:0];
    assign len_clip   = (prefix_length > ipv4lpm_pkg::LEN_W'(ipv4lpm_pkg::ADDR_BITS))
                        ? ipv4lpm_pkg::LEVEL_W'(ipv4lpm_pkg::ADDR_BITS)
                        : ipv4lpm_pkg::LEVEL_W'(prefix_length);
    assign finish     = (kind_reg == ipv4lpm_pkg::KIND_INSERT)
                        ? (ins_end || ((nxt == '0) && pool_empty))
                        : look_end;
    assign busy       = (state_reg != ipv4lpm_pkg::ST_IDLE);

    always_comb
    begin
        upd = ent;
        if (addr_bit)
        begin
            upd.right = new_idx;
        end
        else
        begin
            upd.left = new_idx;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ipv4lpm_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ipv4lpm_pkg::ST_WALK;
                end
            end
            ipv4lpm_pkg::ST_WALK:
            begin
                if (finish)
                begin
                    state_next = ipv4lpm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ipv4lpm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        kind_next     = kind_reg;
        addr_next     = addr_reg;
        len_next      = len_reg;
        port_next     = port_reg;
        level_next    = level_reg;
        cur_next      = cur_reg;
        ent_next      = ent_reg;
        from_mem_next = from_mem_reg;
        have_next     = have_reg;
        best_next     = best_reg;
        used_next     = used_reg;
        rd            = '0;
        wr            = '0;
        result        = '0;
        unique case (state_reg)
            ipv4lpm_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    kind_next     = kind;
                    addr_next     = address[ipv4lpm_pkg::ADDR_BITS-1:0];
                    len_next      = len_clip;
                    port_next     = port_in;
                    level_next    = '0;
                    cur_next      = '0;
                    ent_next      = root;
                    from_mem_next = 1'b0;
                    have_next     = root.valid;
                    best_next     = root.port;
                end
            end
            ipv4lpm_pkg::ST_WALK:
            begin
                if (kind_reg == ipv4lpm_pkg::KIND_INSERT)
                begin
                    priority if (ins_end)
                    begin
                        wr.en          = 1'b1;
                        wr.idx         = cur_reg;
                        wr.entry       = ent;
                        wr.entry.valid = 1'b1;
                        wr.entry.port  = port_reg;
                        result.strobe  = 1'b1;
                    end
                    else if (nxt != '0)
                    begin
                        rd.en         = 1'b1;
                        rd.idx        = nxt;
                        cur_next      = nxt;
                        from_mem_next = 1'b1;
                        level_next    = level_reg + 1'b1;
                        addr_next     = addr_reg << 1;
                    end
                    else if (pool_empty)
                    begin
                        // A node allocated in the previous step is only held in
                        // ent_reg so far; store it so that it reads as empty later.
                        wr.en            = 1'b1;
                        wr.idx           = cur_reg;
                        wr.entry         = ent;
                        result.strobe    = 1'b1;
                        result.pool_full = 1'b1;
                    end
                    else
                    begin
                        wr.en         = 1'b1;
                        wr.idx        = cur_reg;
                        wr.entry      = upd;
                        used_next     = used_reg + 1'b1;
                        cur_next      = new_idx;
                        ent_next      = '0;
                        from_mem_next = 1'b0;
                        level_next    = level_reg + 1'b1;
                        addr_next     = addr_reg << 1;
                    end
                end
                else
                begin
                    if (look_end)
                    begin
                        result.strobe = 1'b1;
                        result.found  = have_eff;
                        result.port   = have_eff ? best_eff : '0;
                    end
                    else
                    begin
                        rd.en         = 1'b1;
                        rd.idx        = nxt;
                        cur_next      = nxt;
                        from_mem_next = 1'b1;
                        have_next     = have_eff;
                        best_next     = best_eff;
                        level_next    = level_reg + 1'b1;
                        addr_next     = addr_reg << 1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ipv4lpm_pkg::ST_IDLE;
            used_reg     <= ipv4lpm_pkg::CNT_W'(1);
            from_mem_reg <= 1'b0;
            have_reg     <= 1'b0;
            kind_reg     <= ipv4lpm_pkg::KIND_INSERT;
            level_reg    <= '0;
            len_reg      <= '0;
            cur_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            used_reg     <= used_next;
            from_mem_reg <= from_mem_next;
            have_reg     <= have_next;
            kind_reg     <= kind_next;
            level_reg    <= level_next;
            len_reg      <= len_next;
            cur_reg      <= cur_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        port_reg <= port_next;
        ent_reg  <= ent_next;
        best_reg <= best_next;
    end

endmodule
`default_nettype wire

/* rtl/ipv4_trie_longest_prefix_match_core.sv */
// Top level of the binary-trie IPv4 longest-prefix-match route table.
// An insert of prefix length L strobes done when the walk reaches level L or the pool runs out.
// A lookup that descends D levels (0 to 32) gives its strobe when the walk stops at level D.
// One node memory read per trie level sets the pace; no new word is taken while a walk is busy.
// The next word is accepted in the strobe cycle; the receiver cannot stall the result.
// Reset leaves an empty table with the root only and needs no clearing pass.
`default_nettype none
module ipv4_trie_longest_prefix_match_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic                           kind,
    input  wire logic [31:0]                    address,
    input  wire logic [ipv4lpm_pkg::LEN_W-1:0]  prefix_length,
    input  wire logic [ipv4lpm_pkg::PORT_W-1:0] port_in,
    output logic                                done,
    output logic                                found,
    output logic [ipv4lpm_pkg::PORT_W-1:0]      port_out,
    output logic                                pool_full
);

    ipv4lpm_pkg::rd_req_t rd;
    ipv4lpm_pkg::wr_req_t wr;
    ipv4lpm_pkg::node_t   rd_data;
    ipv4lpm_pkg::node_t   root;
    ipv4lpm_pkg::result_t result;

    logic                              done_reg;
    logic                              found_reg;
    logic [ipv4lpm_pkg::PORT_W-1:0]    port_reg;
    logic                              pool_full_reg;

    ipv4lpm_node_store u_node_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd      (rd),
        .wr      (wr),
        .rd_data (rd_data),
        .root    (root)
    );

    ipv4lpm_walker u_walker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .kind          (kind),
        .address       (address),
        .prefix_length (prefix_length),
        .port_in       (port_in),
        .rd_data       (rd_data),
        .root          (root),
        .rd            (rd),
        .wr            (wr),
        .result        (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= result.strobe;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result.strobe)
        begin
            found_reg     <= result.found;
            port_reg      <= result.port;
            pool_full_reg <= result.pool_full;
        end
    end

    assign done      = done_reg;
    assign found     = found_reg;
    assign port_out  = port_reg;
    assign pool_full = pool_full_reg;

endmodule
`default_nettype wire

/* rtl/ipv4lpm_checker.sv */
// Port-level checker for the route table core, bound to the top level.
`default_nettype none
`include "ipv4_trie_longest_prefix_match_core_defines.svh"
module ipv4lpm_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           start,
    input wire logic                           busy,
    input wire logic                           done,
    input wire logic                           found,
    input wire logic [ipv4lpm_pkg::PORT_W-1:0] port_out,
    input wire logic                           pool_full
);

    `LPM_ASSERT_NXT(a_accept_busy, start && !busy, busy, "Accepted word did not raise busy.")
    `LPM_ASSERT_IMP(a_done_idle, done, !busy, "Result strobe while still busy.")
    `LPM_ASSERT_IMP(a_fell_done, $fell(busy), done, "Busy fell without a result strobe.")
    `LPM_ASSERT_IMP(a_excl, done, !(found && pool_full), "Found and pool full together.")
    `LPM_ASSERT_IMP(a_miss_zero, done && !found, port_out == '0, "Miss with non-zero port.")

endmodule

bind ipv4_trie_longest_prefix_match_core ipv4lpm_checker u_checker (.*);
`default_nettype wire

/* tb/sv/tb_ipv4_trie_longest_prefix_match_core.sv */
// Self-checking testbench for the IPv4 binary-trie longest-prefix-match route table core.
module tb_ipv4_trie_longest_prefix_match_core;
    timeunit 1ns;
    timeprecision 1ps;

    import ipv4lpm_pkg::*;

    typedef struct packed {
        logic              found;
        logic [PORT_W-1:0] port;
        logic              pool_full;
    } route_result_t;

    class route_table_sb;
        node_idx_t         left_of  [NODE_COUNT];
        node_idx_t         right_of [NODE_COUNT];
        bit                has_port [NODE_COUNT];
        logic [PORT_W-1:0] port_of  [NODE_COUNT];
        int                nodes_used;
        route_result_t     pending [$];
        int                errors;
        int                inserts;
        int                lookups;
        int                hits;
        int                refused;

        function new();
            for (int i = 0; i < NODE_COUNT; i++)
            begin
                left_of[i]  = '0;
                right_of[i] = '0;
                has_port[i] = 1'b0;
                port_of[i]  = '0;
            end
            nodes_used = 1;
            errors     = 0;
            inserts    = 0;
            lookups    = 0;
            hits       = 0;
            refused    = 0;
        endfunction

        task report(input string what);
            errors++;
            if (errors <= 40)
            begin
                $display("ERROR at %0t ns: %s", $time, what);
            end
        endtask

        function bit add_route(input logic [31:0] addr, input logic [LEN_W-1:0] len,
                               input logic [PORT_W-1:0] port);
            int depth;
            int cur;
            int nxt;
            bit b;
            depth = (len > ADDR_BITS) ? ADDR_BITS : int'(len);
            cur   = 0;
            for (int lvl = 0; lvl < depth; lvl++)
            begin
                b   = addr[ADDR_BITS-1-lvl];
                nxt = b ? int'(right_of[cur]) : int'(left_of[cur]);
                if (nxt == 0)
                begin
                    if (nodes_used >= NODE_COUNT)
                    begin
                        return 1'b1;
                    end
                    nxt = nodes_used;
                    nodes_used++;
                    left_of[nxt]  = '0;
                    right_of[nxt] = '0;
                    has_port[nxt] = 1'b0;
                    if (b)
                    begin
                        right_of[cur] = node_idx_t'(nxt);
                    end
                    else
                    begin
                        left_of[cur] = node_idx_t'(nxt);
                    end
                end
                cur = nxt;
            end
            port_of[cur]  = port;
            has_port[cur] = 1'b1;
            return 1'b0;
        endfunction

        function route_result_t match_route(input logic [31:0] addr);
            route_result_t r;
            int cur;
            int nxt;
            r   = '0;
            cur = 0;
            for (int lvl = 0; lvl < ADDR_BITS; lvl++)
            begin
                nxt = addr[ADDR_BITS-1-lvl] ? int'(right_of[cur]) : int'(left_of[cur]);
                if (nxt == 0)
                begin
                    break;
                end
                cur = nxt;
                if (has_port[cur])
                begin
                    r.found = 1'b1;
                    r.port  = port_of[cur];
                end
            end
            if (!r.found && has_port[0])
            begin
                r.found = 1'b1;
                r.port  = port_of[0];
            end
            return r;
        endfunction

        function void note_word(input logic kind, input logic [31:0] addr,
                                input logic [LEN_W-1:0] len, input logic [PORT_W-1:0] port);
            route_result_t r;
            r = '0;
            if (kind == KIND_INSERT)
            begin
                inserts++;
                r.pool_full = add_route(addr, len, port);
                if (r.pool_full)
                begin
                    refused++;
                end
            end
            else
            begin
                lookups++;
                r = match_route(addr);
                if (r.found)
                begin
                    hits++;
                end
            end
            pending.push_back(r);
        endfunction

        task check_result(input logic found, input logic [PORT_W-1:0] port,
                          input logic pool_full);
            route_result_t exp_r;
            if (pending.size() == 0)
            begin
                report("result word arrived with nothing outstanding");
                return;
            end
            exp_r = pending.pop_front();
            if (found !== exp_r.found)
            begin
                report($sformatf("found %b, expected %b", found, exp_r.found));
            end
            if (port !== exp_r.port)
            begin
                report($sformatf("port_out %0d, expected %0d", port, exp_r.port));
            end
            if (pool_full !== exp_r.pool_full)
            begin
                report($sformatf("pool_full %b, expected %b", pool_full, exp_r.pool_full));
            end
        endtask

        task check_drained();
            if (pending.size() != 0)
            begin
                report($sformatf("%0d result words never arrived", pending.size()));
            end
        endtask
    endclass

    logic              clk           = 1'b0;
    logic              rst_n         = 1'b0;
    logic              start         = 1'b0;
    logic              kind          = KIND_INSERT;
    logic [31:0]       address       = '0;
    logic [LEN_W-1:0]  prefix_length = '0;
    logic [PORT_W-1:0] port_in       = '0;
    logic              busy;
    logic              done;
    logic              found;
    logic [PORT_W-1:0] port_out;
    logic              pool_full;

    route_table_sb sb;
    bit            quiet;
    logic [31:0]   regions [8];
    logic [31:0]   known_addr [$];
    int            known_len [$];

    ipv4_trie_longest_prefix_match_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .kind         (kind),
        .address      (address),
        .prefix_length(prefix_length),
        .port_in      (port_in),
        .done         (done),
        .found        (found),
        .port_out     (port_out),
        .pool_full    (pool_full)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            sb.check_result(found, port_out, pool_full);
        end
    end

    task automatic send_word(input logic k, input logic [31:0] a, input int len,
                             input logic [PORT_W-1:0] p);
        int gap;
        int slot;
        gap = quiet ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start         <= 1'b1;
        kind          <= k;
        address       <= a;
        prefix_length <= LEN_W'(len);
        port_in       <= p;
        @(posedge clk);
        while (busy) @(posedge clk);
        sb.note_word(k, a, LEN_W'(len), p);
        if (k == KIND_INSERT)
        begin
            if (known_addr.size() < 256)
            begin
                known_addr.push_back(a);
                known_len.push_back((len > ADDR_BITS) ? ADDR_BITS : len);
            end
            else
            begin
                slot             = $urandom_range(0, 255);
                known_addr[slot] = a;
                known_len[slot]  = (len > ADDR_BITS) ? ADDR_BITS : len;
            end
        end
    endtask

    task automatic send_random(input bit fill_mode);
        logic        k;
        logic [31:0] a;
        logic [31:0] mask;
        int          len;
        int          src;
        int          roll;
        int          j;
        int          klen;
        k   = ($urandom_range(0, 99) < (fill_mode ? 75 : 45)) ? KIND_INSERT : KIND_LOOKUP;
        src = $urandom_range(0, 99) + (fill_mode ? 40 : 0);
        if (src < 50 && known_addr.size() > 0)
        begin
            j    = $urandom_range(0, known_addr.size() - 1);
            klen = known_len[j];
            mask = (klen == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - klen));
            a    = (known_addr[j] & mask) | ($urandom & ~mask);
            if ($urandom_range(0, 4) == 0)
            begin
                a = a ^ (32'h1 << $urandom_range(0, 31));
            end
        end
        else if (src < 80)
        begin
            a = {regions[$urandom_range(0, 7)][31:12], 12'($urandom)};
        end
        else
        begin
            a = $urandom;
        end
        roll = $urandom_range(0, 99);
        if (roll < 8)
        begin
            len = 0;
        end
        else if (roll < 16)
        begin
            len = $urandom_range(33, 63);
        end
        else if (fill_mode)
        begin
            len = $urandom_range(20, 32);
        end
        else
        begin
            len = $urandom_range(1, $urandom_range(1, 32));
        end
        send_word(k, a, len, PORT_W'($urandom));
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending.size() != 0);
    endtask

    task automatic run_phase(input int count, input bit fill_mode);
        for (int n = 0; n < count; n++)
        begin
            quiet = ((n / 40) % 3) == 1;
            send_random(fill_mode);
        end
        quiet = 1'b0;
        wait_drained();
    endtask

    initial
    begin
        #4_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        sb    = new();
        quiet = 1'b0;
        for (int i = 0; i < 8; i++)
        begin
            regions[i] = $urandom;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(KIND_LOOKUP, 32'h0000_0000, 0, 8'h00);
        send_word(KIND_LOOKUP, 32'hFFFF_FFFF, 63, 8'hFF);
        send_word(KIND_INSERT, 32'h1234_5678, 0, 8'h07);
        send_word(KIND_LOOKUP, 32'hC0A8_0001, 0, 8'h00);
        send_word(KIND_INSERT, 32'h0A00_0000, 8, 8'hFF);
        send_word(KIND_LOOKUP, 32'h0A01_0203, 0, 8'h00);
        send_word(KIND_INSERT, 32'h0A01_0000, 16, 8'h00);
        send_word(KIND_LOOKUP, 32'h0A01_0203, 0, 8'h00);
        send_word(KIND_LOOKUP, 32'h0A02_0000, 0, 8'h00);
        send_word(KIND_INSERT, 32'h0A01_FFFF, 16, 8'h21);
        send_word(KIND_LOOKUP, 32'h0A01_0909, 0, 8'h00);
        send_word(KIND_INSERT, 32'hFFFF_FFFF, 32, 8'h80);
        send_word(KIND_LOOKUP, 32'hFFFF_FFFF, 32, 8'h00);
        send_word(KIND_LOOKUP, 32'hFFFF_FFFE, 0, 8'h00);
        send_word(KIND_INSERT, 32'h0000_0000, 32, 8'h01);
        send_word(KIND_LOOKUP, 32'h0000_0000, 0, 8'h00);
        send_word(KIND_LOOKUP, 32'h0000_0001, 0, 8'h00);
        send_word(KIND_INSERT, 32'hA5A5_A5A5, 63, 8'hC8);
        send_word(KIND_LOOKUP, 32'hA5A5_A5A5, 0, 8'h00);
        send_word(KIND_INSERT, 32'h5A5A_5A5A, 33, 8'hAA);
        send_word(KIND_LOOKUP, 32'h5A5A_5A5A, 0, 8'h00);
        send_word(KIND_INSERT, 32'h8000_0000, 1, 8'h55);
        send_word(KIND_LOOKUP, 32'hC0A8_0001, 0, 8'h00);
        send_word(KIND_INSERT, 32'h0000_0000, 0, 8'hFF);
        send_word(KIND_LOOKUP, 32'h7F00_0001, 0, 8'h00);
        wait_drained();

        run_phase(800, 1'b0);
        run_phase(500, 1'b1);
        run_phase(400, 1'b0);

        for (int c = 0; c < 200 && sb.pending.size() != 0; c++)
        begin
            @(posedge clk);
        end
        repeat (40) @(posedge clk);
        sb.check_drained();

        $display("Covered %0d inserts (%0d refused for lack of nodes) and %0d lookups (%0d hits).",
                 sb.inserts, sb.refused, sb.lookups, sb.hits);
        $display("Trie grew to %0d of %0d nodes; %0d mismatches counted.",
                 sb.nodes_used, NODE_COUNT, sb.errors);
        if (sb.errors == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
